// ----- hdl/hdlcr_pkg.sv -----
// shared types, constants and the fcs-16 byte update for the hdlc receiver
package hdlcr_pkg;

  // framing bytes
  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_OR    = 8'h20;

  // fcs-16, reflected form
  localparam logic [15:0] CRC_PRESET = 16'hFFFF;
  localparam logic [15:0] CRC_GOOD   = 16'hF0B8;
  localparam logic [15:0] CRC_POLY   = 16'h8408;

  // widths fixed by the field definitions
  localparam int unsigned LEN_W = 14;
  localparam int unsigned ST_W  = 3;

  // defaults handed to the top level
  localparam int unsigned DEFAULT_BUFFER_BYTES = 8192;
  localparam int unsigned DEFAULT_QUEUE_DEPTH  = 2;
  localparam logic [7:0]  PROTO_RESET          = 8'h21;

  // frame status codes
  localparam logic [ST_W-1:0] ST_OK          = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY       = 3'd1;
  localparam logic [ST_W-1:0] ST_FCS_BAD     = 3'd2;
  localparam logic [ST_W-1:0] ST_WRONG_PROTO = 3'd3;
  localparam logic [ST_W-1:0] ST_SHORT       = 3'd4;
  localparam logic [ST_W-1:0] ST_OVERFLOW    = 3'd5;

  // classified token passed from front to back
  typedef enum logic [1:0] {
    TOK_DATA     = 2'd0,
    TOK_CLOSE    = 2'd1,
    TOK_OVERFLOW = 2'd2
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e  kind;
    logic [7:0] data;
  } token_t;

  // one byte through the reflected crc, bit by bit
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] d);
    logic [15:0] c;
    c = crc ^ {8'h00, d};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- hdl/hdlcr_front.sv -----
// front end: flag hunt, escape removal and raw length bound, emits tokens
module hdlcr_front #(
  parameter int unsigned BUFFER_BYTES = hdlcr_pkg::DEFAULT_BUFFER_BYTES
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [7:0]      in_byte_i,
  output logic            in_stall_o,
  output logic            push_o,
  output hdlcr_pkg::token_t token_o,
  input  logic            full_i
);
  import hdlcr_pkg::*;

  localparam int unsigned RAW_W = $clog2(BUFFER_BYTES + 1);

  logic             hunting_q, hunting_d;
  logic             esc_q, esc_d;
  logic [RAW_W-1:0] raw_q, raw_d;
  logic             take;

  assign in_stall_o = full_i;
  assign take       = in_valid_i & ~full_i;

  // classify the incoming byte
  always_comb begin
    hunting_d     = hunting_q;
    esc_d         = esc_q;
    raw_d         = raw_q;
    push_o        = 1'b0;
    token_o.kind  = TOK_DATA;
    token_o.data  = in_byte_i;
    if (take) begin
      if (in_byte_i == FLAG_BYTE) begin
        if (!hunting_q) begin
          push_o       = 1'b1;
          token_o.kind = TOK_CLOSE;
        end
        hunting_d = 1'b0;
        esc_d     = 1'b0;
        raw_d     = '0;
      end else if (!hunting_q) begin
        if (raw_q == RAW_W'(BUFFER_BYTES)) begin
          push_o       = 1'b1;
          token_o.kind = TOK_OVERFLOW;
          hunting_d    = 1'b1;
          esc_d        = 1'b0;
          raw_d        = '0;
        end else begin
          raw_d = raw_q + RAW_W'(1);
          if (esc_q) begin
            esc_d        = 1'b0;
            push_o       = 1'b1;
            token_o.data = in_byte_i | ESC_OR;
          end else if (in_byte_i == ESC_BYTE) begin
            esc_d = 1'b1;
          end else begin
            push_o = 1'b1;
          end
        end
      end
    end
  end

  // front state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hunting_q <= 1'b1;
      esc_q     <= 1'b0;
      raw_q     <= '0;
    end else begin
      hunting_q <= hunting_d;
      esc_q     <= esc_d;
      raw_q     <= raw_d;
    end
  end

endmodule

// ----- hdl/hdlcr_queue.sv -----
// short token queue between front and back
module hdlcr_queue #(
  parameter int unsigned DEPTH = hdlcr_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  hdlcr_pkg::token_t token_i,
  output logic              full_o,
  output logic              valid_o,
  output hdlcr_pkg::token_t token_o,
  input  logic              pop_i
);
  import hdlcr_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  token_t           entries_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign token_o = entries_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_q] <= token_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

// ----- hdl/hdlcr_back.sv -----
// back end: fcs check, protocol filter, two-byte hold-back and status records
module hdlcr_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic [7:0]                 cfg_data_i,
  input  logic                       tok_valid_i,
  input  hdlcr_pkg::token_t          token_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [7:0]                 out_byte_o,
  output logic                       frame_end_o,
  output logic [hdlcr_pkg::ST_W-1:0] frame_status_o,
  output logic [hdlcr_pkg::LEN_W-1:0] payload_len_o
);
  import hdlcr_pkg::*;

  logic [7:0]       proto_q;
  logic [15:0]      crc_q, crc_d;
  logic [LEN_W-1:0] dec_q, dec_d;
  logic             match_q, match_d;
  logic [7:0]       held0_q, held0_d, held1_q, held1_d;

  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             frame_end_q, frame_end_d;
  logic [ST_W-1:0]  status_q, status_d;
  logic [LEN_W-1:0] len_q, len_d;

  logic             out_free, emit;
  logic [LEN_W-1:0] delivered;
  logic [ST_W-1:0]  close_status;

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign pop_o    = tok_valid_i & out_free;

  // payload count for the status record
  assign delivered = (match_q && dec_q >= LEN_W'(3)) ? dec_q - LEN_W'(3) : '0;

  // status at a closing flag, first match wins
  always_comb begin
    priority if (dec_q == '0)       close_status = ST_EMPTY;
    else if (crc_q != CRC_GOOD)     close_status = ST_FCS_BAD;
    else if (dec_q < LEN_W'(3))     close_status = ST_SHORT;
    else if (!match_q)              close_status = ST_WRONG_PROTO;
    else                            close_status = ST_OK;
  end

  // token execution
  always_comb begin
    crc_d       = crc_q;
    dec_d       = dec_q;
    match_d     = match_q;
    held0_d     = held0_q;
    held1_d     = held1_q;
    emit        = 1'b0;
    out_byte_d  = out_byte_q;
    frame_end_d = frame_end_q;
    status_d    = status_q;
    len_d       = len_q;
    if (pop_o) begin
      unique case (token_i.kind)
        TOK_DATA: begin
          crc_d = crc16_byte(crc_q, token_i.data);
          if (dec_q == '0) begin
            match_d = (token_i.data == proto_q);
          end else begin
            if (dec_q >= LEN_W'(3) && match_q) begin
              emit        = 1'b1;
              out_byte_d  = held0_q;
              frame_end_d = 1'b0;
              status_d    = ST_OK;
              len_d       = '0;
            end
            held0_d = held1_q;
            held1_d = token_i.data;
          end
          if (dec_q != '1) begin
            dec_d = dec_q + LEN_W'(1);
          end
        end
        TOK_CLOSE, TOK_OVERFLOW: begin
          emit        = 1'b1;
          out_byte_d  = '0;
          frame_end_d = 1'b1;
          status_d    = (token_i.kind == TOK_OVERFLOW) ? ST_OVERFLOW : close_status;
          len_d       = delivered;
          crc_d       = CRC_PRESET;
          dec_d       = '0;
          match_d     = 1'b0;
        end
        default: begin
        end
      endcase
    end
    out_valid_d = out_free ? emit : out_valid_q;
  end

  // frame state and config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proto_q     <= PROTO_RESET;
      crc_q       <= CRC_PRESET;
      dec_q       <= '0;
      match_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        proto_q <= cfg_data_i;
      end
      crc_q       <= crc_d;
      dec_q       <= dec_d;
      match_q     <= match_d;
      out_valid_q <= out_valid_d;
    end
  end

  // held bytes and output payload
  always_ff @(posedge clk_i) begin
    held0_q     <= held0_d;
    held1_q     <= held1_d;
    out_byte_q  <= out_byte_d;
    frame_end_q <= frame_end_d;
    status_q    <= status_d;
    len_q       <= len_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign frame_end_o    = frame_end_q;
  assign frame_status_o = status_q;
  assign payload_len_o  = len_q;

endmodule

// ----- hdl/hdlc_frame_receiver_fcs16.sv -----
// top level of the hdlc frame receiver with fcs-16 check
//
//  channel  | signals                                         | role
//  ---------+-------------------------------------------------+---------------------
//  in       | in_valid_i, in_stall_o, in_byte_i               | raw byte stream
//  out      | out_valid_o, out_stall_i, out_byte_o,           | payload bytes and
//           | frame_end_o, frame_status_o, payload_len_o      | end-of-frame records
//  cfg      | cfg_valid_i, cfg_ready_o, cfg_data_i            | expected protocol
//
//  one byte is taken per cycle while in_stall_o is low; a result leaves the back
//  end in the cycle after its token is popped. throughput is one byte per cycle,
//  set by the crc update step. reset puts the front in flag hunt, presets the fcs
//  and clears the counters; no sweep. the token queue (QUEUE_DEPTH entries) absorbs
//  output stalls; in_stall_o rises only when it is full. cfg is always ready.
module hdlc_frame_receiver_fcs16 #(
  parameter int unsigned BUFFER_BYTES = hdlcr_pkg::DEFAULT_BUFFER_BYTES,
  parameter int unsigned QUEUE_DEPTH  = hdlcr_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  in_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  out_byte_o,
  output logic                        frame_end_o,
  output logic [hdlcr_pkg::ST_W-1:0]  frame_status_o,
  output logic [hdlcr_pkg::LEN_W-1:0] payload_len_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [7:0]                  cfg_data_i
);
  import hdlcr_pkg::*;

  token_t push_tok, head_tok;
  logic   push, full, head_valid, pop;

  assign cfg_ready_o = 1'b1;

  // byte classification
  hdlcr_front #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_byte_i  (in_byte_i),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .token_o    (push_tok),
    .full_i     (full)
  );

  // decoupling queue
  hdlcr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .token_i (push_tok),
    .full_o  (full),
    .valid_o (head_valid),
    .token_o (head_tok),
    .pop_i   (pop)
  );

  // frame checking and output
  hdlcr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .tok_valid_i    (head_valid),
    .token_i        (head_tok),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .frame_end_o    (frame_end_o),
    .frame_status_o (frame_status_o),
    .payload_len_o  (payload_len_o)
  );

endmodule

// ----- bench/tb.sv -----
// self-checking testbench for the hdlc frame receiver with fcs-16 check
module tb;
  import hdlcr_pkg::*;

  localparam int unsigned BUF_BYTES   = DEFAULT_BUFFER_BYTES;
  localparam int unsigned CYCLE_LIMIT = 10_000_000;
  localparam int unsigned RANDOM_BYTES = 1900;
  localparam int unsigned CFG_EVERY   = 250;
  localparam int unsigned SHOW_LIMIT  = 10;

  // how a frame body is escaped on the wire
  typedef enum int {
    ESC_PLAIN,
    ESC_RANDOM,
    ESC_ALL
  } esc_style_e;

  // one output transfer
  typedef struct packed {
    logic [7:0]       data;
    logic             last;
    logic [ST_W-1:0]  status;
    logic [LEN_W-1:0] len;
  } rx_record_t;

  // fcs-16 update, fed one data bit at a time
  function automatic logic [15:0] fcs_step(logic [15:0] acc, logic [7:0] d);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      fb = r[0] ^ d[k];
      r  = {1'b0, r[15:1]};
      if (fb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  // predicts the receiver's output and checks what it delivers
  class deframe_scoreboard;
    logic [7:0]  want_proto;
    bit          hunt;
    int unsigned raw_bytes;
    bit          esc_seen;
    logic [15:0] fcs;
    logic [7:0]  held[2];
    int unsigned dec_bytes;
    bit          proto_ok;
    int unsigned buf_limit;
    int unsigned mismatches;
    rx_record_t  expected_out[$];

    function new(int unsigned buf_bytes);
      buf_limit  = buf_bytes;
      want_proto = PROTO_RESET;
      hunt       = 1'b1;
      mismatches = 0;
      held[0]    = 8'h00;
      held[1]    = 8'h00;
      open_frame();
    endfunction

    function void open_frame();
      raw_bytes = 0;
      esc_seen  = 1'b0;
      fcs       = CRC_PRESET;
      dec_bytes = 0;
      proto_ok  = 1'b0;
    endfunction

    function void set_protocol(logic [7:0] p);
      want_proto = p;
    endfunction

    function int pending();
      return expected_out.size();
    endfunction

    function void push_status(logic [ST_W-1:0] st);
      rx_record_t rec;
      rec.data   = 8'h00;
      rec.last   = 1'b1;
      rec.status = st;
      rec.len    = (proto_ok && dec_bytes >= 3) ? LEN_W'(dec_bytes - 3) : '0;
      expected_out.push_back(rec);
    endfunction

    // one unescaped byte of the frame
    function void decode(logic [7:0] d);
      rx_record_t rec;
      fcs = fcs_step(fcs, d);
      if (dec_bytes == 0) begin
        proto_ok = (d == want_proto);
      end else begin
        if (dec_bytes >= 3 && proto_ok) begin
          rec.data   = held[0];
          rec.last   = 1'b0;
          rec.status = ST_OK;
          rec.len    = '0;
          expected_out.push_back(rec);
        end
        held[0] = held[1];
        held[1] = d;
      end
      if (dec_bytes < (1 << LEN_W) - 1) dec_bytes++;
    endfunction

    // accepted input transfer
    function void take_byte(logic [7:0] b);
      if (b == FLAG_BYTE) begin
        if (hunt) begin
          hunt = 1'b0;
          open_frame();
          return;
        end
        if (dec_bytes == 0) push_status(ST_EMPTY);
        else if (fcs != CRC_GOOD) push_status(ST_FCS_BAD);
        else if (dec_bytes < 3) push_status(ST_SHORT);
        else if (!proto_ok) push_status(ST_WRONG_PROTO);
        else push_status(ST_OK);
        open_frame();
        return;
      end
      if (hunt) return;
      if (raw_bytes >= buf_limit) begin
        push_status(ST_OVERFLOW);
        open_frame();
        hunt = 1'b1;
        return;
      end
      raw_bytes++;
      if (esc_seen) begin
        esc_seen = 1'b0;
        decode(b | ESC_OR);
      end else if (b == ESC_BYTE) begin
        esc_seen = 1'b1;
      end else begin
        decode(b);
      end
    endfunction

    function string show(rx_record_t r);
      return $sformatf("byte %02h end %0d status %0d len %0d",
                       r.data, r.last, r.status, r.len);
    endfunction

    // accepted output transfer
    function void check_record(rx_record_t got);
      rx_record_t want;
      if (expected_out.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("unexpected output transfer: %s", show(got));
        return;
      end
      want = expected_out.pop_front();
      if (want.data !== got.data || want.last !== got.last ||
          want.status !== got.status || want.len !== got.len) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("output mismatch: expected %s, got %s", show(want), show(got));
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          in_byte = 8'h00;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [7:0]          out_byte;
  logic                frame_end;
  logic [ST_W-1:0]     frame_status;
  logic [LEN_W-1:0]    payload_len;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [7:0]          cfg_data = 8'h00;

  deframe_scoreboard   sb;
  logic [7:0]          frame_q[$];
  logic [7:0]          cur_proto = PROTO_RESET;
  int unsigned         bytes_taken = 0;
  int unsigned         taken_since_cfg = 0;
  int unsigned         cycle_count = 0;
  int unsigned         stall_hold = 0;
  bit                  calm = 1'b0;

  hdlc_frame_receiver_fcs16 #(
    .BUFFER_BYTES (BUF_BYTES)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .in_byte_i      (in_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_byte_o     (out_byte),
    .frame_end_o    (frame_end),
    .frame_status_o (frame_status),
    .payload_len_o  (payload_len),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // cycle count, quiet stretches and the run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 300 == 0) calm <= ($urandom_range(0, 3) == 0);
    if (cycle_count == CYCLE_LIMIT) begin
      $display("hdlc_frame_receiver_fcs16 verification failed");
      $finish;
    end
  end

  // idle length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // output back-pressure
  always @(negedge clk_i) begin : stall_gen
    int unsigned len;
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      len = idle_len();
      out_stall  <= (len != 0);
      stall_hold <= (len == 0) ? 0 : len - 1;
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall)
      sb.check_record('{out_byte, frame_end, frame_status, payload_len});
  end

  // one input transfer, with a random gap ahead of it
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = idle_len();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk_i); while (in_stall);
    sb.take_byte(b);
    bytes_taken++;
    taken_since_cfg++;
  endtask

  task automatic in_release();
    @(negedge clk_i);
    in_valid <= 1'b0;
  endtask

  // register write once the receiver has drained
  task automatic write_protocol(input logic [7:0] p);
    in_release();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= p;
    do @(posedge clk_i); while (!cfg_ready);
    sb.set_protocol(p);
    cur_proto = p;
    taken_since_cfg = 0;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] frame_fcs();
    logic [15:0] acc;
    acc = CRC_PRESET;
    foreach (frame_q[k]) acc = fcs_step(acc, frame_q[k]);
    return acc;
  endfunction

  // protocol byte then n payload bytes, framing bytes frequent
  function automatic void fill_frame(input logic [7:0] p, input int unsigned n);
    frame_q = {};
    frame_q.push_back(p);
    repeat (n) begin
      if ($urandom_range(0, 99) < 15)
        frame_q.push_back($urandom_range(0, 1) ? FLAG_BYTE : ESC_BYTE);
      else
        frame_q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // appends the fcs, escapes the body and closes with a flag
  task automatic send_frame(input bit spoil, input bit dangling, input esc_style_e style);
    logic [15:0] f;
    logic [7:0]  d;
    logic [7:0]  flip;
    int unsigned pick;
    bit          esc;
    f = ~frame_fcs();
    frame_q.push_back(f[7:0]);
    frame_q.push_back(f[15:8]);
    if (spoil) begin
      pick = $urandom_range(0, frame_q.size() - 1);
      flip = 8'h01 << $urandom_range(0, 7);
      frame_q[pick] = frame_q[pick] ^ flip;
    end
    foreach (frame_q[k]) begin
      d   = frame_q[k];
      esc = (d == FLAG_BYTE) || (d == ESC_BYTE) ||
            (style == ESC_ALL && d[5]) ||
            (style == ESC_RANDOM && d[5] && $urandom_range(0, 7) == 0);
      if (esc) begin
        send_byte(ESC_BYTE);
        if (d == FLAG_BYTE || (style != ESC_ALL && $urandom_range(0, 1) == 0))
          send_byte(d & ~ESC_OR);
        else
          send_byte(d);
      end else begin
        send_byte(d);
      end
    end
    if (dangling) send_byte(ESC_BYTE);
    send_byte(FLAG_BYTE);
  endtask

  initial begin : stimulus
    int unsigned r;
    int unsigned n;
    logic [7:0]  p;
    logic [7:0]  v;
    logic [15:0] f;

    sb = new(BUF_BYTES);
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: noise while hunting, then flag handling and each status
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ESC_BYTE);
    send_byte(FLAG_BYTE);
    send_byte(FLAG_BYTE);
    fill_frame(PROTO_RESET, 0);
    send_frame(1'b0, 1'b0, ESC_RANDOM);
    frame_q = {};
    send_frame(1'b0, 1'b0, ESC_PLAIN);
    frame_q = '{PROTO_RESET, FLAG_BYTE, ESC_BYTE, 8'h00, 8'hFF};
    send_frame(1'b0, 1'b0, ESC_RANDOM);
    frame_q = '{PROTO_RESET, 8'h55};
    send_frame(1'b1, 1'b0, ESC_RANDOM);
    frame_q = '{8'h33, 8'h01};
    send_frame(1'b0, 1'b0, ESC_RANDOM);
    // trailing escape before the flag
    frame_q = '{PROTO_RESET, 8'hAA};
    send_frame(1'b0, 1'b1, ESC_PLAIN);
    // double escape and literal escaped bytes
    frame_q = '{PROTO_RESET, ESC_BYTE, 8'h60};
    send_frame(1'b0, 1'b0, ESC_ALL);
    // lone byte with no fcs, then an escape straight into a flag
    send_byte(PROTO_RESET);
    send_byte(FLAG_BYTE);
    send_byte(ESC_BYTE);
    send_byte(FLAG_BYTE);

    // protocol register at its extremes
    write_protocol(8'h00);
    fill_frame(8'h00, 3);
    send_frame(1'b0, 1'b0, ESC_RANDOM);
    fill_frame(PROTO_RESET, 3);
    send_frame(1'b0, 1'b0, ESC_RANDOM);
    write_protocol(8'hFF);
    fill_frame(8'hFF, 4);
    send_frame(1'b0, 1'b0, ESC_RANDOM);
    write_protocol(FLAG_BYTE);
    fill_frame(FLAG_BYTE, 4);
    send_frame(1'b0, 1'b0, ESC_RANDOM);
    write_protocol(PROTO_RESET);

    // frame of exactly the buffer size with no escapes on the wire
    frame_q = {};
    frame_q.push_back(PROTO_RESET);
    repeat (BUF_BYTES - 3) begin
      do v = 8'($urandom_range(0, 255)); while (v == FLAG_BYTE || v == ESC_BYTE);
      frame_q.push_back(v);
    end
    f = ~frame_fcs();
    while (f[7:0] == FLAG_BYTE || f[7:0] == ESC_BYTE ||
           f[15:8] == FLAG_BYTE || f[15:8] == ESC_BYTE) begin
      do v = 8'($urandom_range(0, 255)); while (v == FLAG_BYTE || v == ESC_BYTE);
      frame_q[$] = v;
      f = ~frame_fcs();
    end
    send_frame(1'b0, 1'b0, ESC_PLAIN);

    // one byte past the buffer: overflow, then ignored bytes until a flag
    send_byte(PROTO_RESET);
    repeat (BUF_BYTES + 3) begin
      do v = 8'($urandom_range(0, 255)); while (v == FLAG_BYTE);
      send_byte(v);
    end
    send_byte(FLAG_BYTE);

    // random frames, register changed now and then
    bytes_taken = 0;
    while (bytes_taken < RANDOM_BYTES) begin
      if (taken_since_cfg >= CFG_EVERY) begin
        r = $urandom_range(0, 9);
        if (r == 0) write_protocol(8'h00);
        else if (r == 1) write_protocol(8'hFF);
        else write_protocol(8'($urandom_range(0, 255)));
      end
      r = $urandom_range(0, 99);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
      p = ($urandom_range(0, 99) < 85) ? cur_proto : 8'($urandom_range(0, 255));
      if (r < 60) begin
        fill_frame(p, n);
        send_frame(1'b0, 1'b0, ESC_RANDOM);
      end else if (r < 72) begin
        fill_frame(p, n);
        send_frame(1'b1, 1'b0, ESC_RANDOM);
      end else if (r < 80) begin
        fill_frame(p, n);
        send_frame(1'b0, 1'b1, ESC_RANDOM);
      end else if (r < 86) begin
        send_byte(FLAG_BYTE);
      end else if (r < 92) begin
        // short frames, with or without a valid fcs
        fill_frame(p, 0);
        if ($urandom_range(0, 1) == 0) frame_q = {};
        if ($urandom_range(0, 1) == 0) begin
          send_frame(1'b0, 1'b0, ESC_RANDOM);
        end else begin
          send_byte(p);
          if ($urandom_range(0, 1) == 0) send_byte(8'($urandom_range(0, 255)));
          send_byte(FLAG_BYTE);
        end
      end else begin
        // line noise between flags
        repeat ($urandom_range(1, 10)) send_byte(8'($urandom_range(0, 255)));
        send_byte(FLAG_BYTE);
      end
    end

    // drain and settle
    in_release();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0)
      $display("hdlc_frame_receiver_fcs16 verification clean");
    else
      $display("hdlc_frame_receiver_fcs16 verification failed");
    $finish;
  end

endmodule

// ----- hdlc_frame_receiver_fcs16.f -----
hdl/hdlcr_pkg.sv
hdl/hdlcr_front.sv
hdl/hdlcr_queue.sv
hdl/hdlcr_back.sv
hdl/hdlc_frame_receiver_fcs16.sv
bench/tb.sv
